/* design/lru_block_buffer_cache_top_defines.svh */
// Assertion macros for the block buffer cache manager.
// Included by the top level; defining ASSERT_OFF compiles every check away.
`ifndef LRU_BLOCK_BUFFER_CACHE_TOP_DEFINES_SVH
`define LRU_BLOCK_BUFFER_CACHE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// A property that must hold in the same cycle as its antecedent.
`define LBC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbc assertion failed");

// A property whose consequent must hold in the cycle after its antecedent.
`define LBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbc assertion failed");

`else

`define LBC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LBC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/lbc_pkg.sv */
// Shared types and constants of the block buffer cache manager.
// No dependencies; used by the channel interfaces, the entry cell and the top level.
`default_nettype none

package lbc_pkg;

   localparam int DEV_W   = 8;
   localparam int BLK_W   = 32;
   localparam int SLOT_W  = 5;
   localparam int TICK_W  = 31;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
   localparam logic [TIME_W-1:0]  TIME_NEVER = '1;

   typedef enum logic [1:0] {
      FN_GET     = 2'd0,
      FN_RELEASE = 2'd1,
      FN_PIN     = 2'd2,
      FN_UNPIN   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Update applied to one entry when a request completes.
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_HIT     = 3'd1,
      CMD_FILL    = 3'd2,
      CMD_PIN     = 3'd3,
      CMD_DEC     = 3'd4,
      CMD_RELEASE = 3'd5
   } cmd_op_type;

   // Broadcast from the top level to every cell: search key and update.
   typedef struct packed {
      cmd_op_type        op;
      logic [DEV_W-1:0]  dev;
      logic [BLK_W-1:0]  blk;
      logic [TICK_W-1:0] tick;
   } cmd_type;

   // Flags of the search token that walks down the row of cells.
   typedef struct packed {
      logic active;
      logic hit;
      logic hit_valid;
      logic free;
   } carry_type;

endpackage

`default_nettype wire

/* design/lbc_ifs.sv */
// Request and response channel interfaces of the block buffer cache manager.
// Depends on lbc_pkg for field widths and codes.
`default_nettype none

interface lbc_req_if;
   import lbc_pkg::*;

   logic                 valid;
   logic                 ready;
   func_type             func;
   logic [DEV_W-1:0]     device_number;
   logic [BLK_W-1:0]     block_number;
   logic [SLOT_W-1:0]    buffer_slot;
   logic [TICK_W-1:0]    now_tick;

   modport source (
      output valid, func, device_number, block_number, buffer_slot, now_tick,
      input  ready
   );
   modport sink (
      input  valid, func, device_number, block_number, buffer_slot, now_tick,
      output ready
   );
endinterface

interface lbc_rsp_if;
   import lbc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [SLOT_W-1:0]    slot_index;
   logic                 was_hit;
   logic                 needs_read;
   status_type           status;

   modport source (
      output valid, slot_index, was_hit, needs_read, status,
      input  ready
   );
   modport sink (
      input  valid, slot_index, was_hit, needs_read, status,
      output ready
   );
endinterface

`default_nettype wire

/* design/lbc_cell.sv */
// One cache entry: tag, reference count, data-valid mark and last-use time,
// plus one stage of the lookup token. Depends on lbc_pkg.
`default_nettype none

module lbc_cell #(
   parameter int IDX_W    = 5,
   parameter int CELL_IDX = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  lbc_pkg::cmd_type  cmd_i,
   input  wire  [IDX_W-1:0]        cmd_idx_i,
   input  wire  lbc_pkg::carry_type carry_i,
   input  wire  [IDX_W-1:0]        hit_idx_i,
   input  wire  [IDX_W-1:0]        free_idx_i,
   input  wire  [lbc_pkg::TIME_W-1:0] free_time_i,
   output lbc_pkg::carry_type      carry_o,
   output logic [IDX_W-1:0]        hit_idx_o,
   output logic [IDX_W-1:0]        free_idx_o,
   output logic [lbc_pkg::TIME_W-1:0] free_time_o,
   output logic                    zero_o
);
   import lbc_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [DEV_W-1:0]   tag_dev_ff, tag_dev_in;
   logic [BLK_W-1:0]   tag_blk_ff, tag_blk_in;
   logic               present_ff, present_in;
   logic               valid_ff, valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]  time_ff, time_in;

   carry_type          carry_ff, carry_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [TIME_W-1:0]  free_time_ff, free_time_in;

   logic               match;
   logic               take_free;
   logic               sel;

   // Lookup stage: the first matching entry wins the hit, and the oldest
   // unreferenced entry (earlier one on ties) wins the free slot.
   always_comb begin
      match     = present_ff && (tag_dev_ff == cmd_i.dev) && (tag_blk_ff == cmd_i.blk);
      take_free = (count_ff == '0) &&
                  (!carry_i.free || ($signed(time_ff) < $signed(free_time_i)));

      carry_in     = carry_i;
      hit_idx_in   = hit_idx_i;
      free_idx_in  = free_idx_i;
      free_time_in = free_time_i;
      if (!carry_i.hit && match) begin
         carry_in.hit       = 1'b1;
         carry_in.hit_valid = valid_ff;
         hit_idx_in         = MY_IDX;
      end
      if (take_free) begin
         carry_in.free = 1'b1;
         free_idx_in   = MY_IDX;
         free_time_in  = time_ff;
      end
   end

   always_comb begin
      sel        = (cmd_idx_i == MY_IDX);
      tag_dev_in = tag_dev_ff;
      tag_blk_in = tag_blk_ff;
      present_in = present_ff;
      valid_in   = valid_ff;
      count_in   = count_ff;
      time_in    = time_ff;
      if (sel) begin
         case (cmd_i.op)
            CMD_HIT: begin
               valid_in = 1'b1;
               if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_ONE;
            end
            CMD_FILL: begin
               tag_dev_in = cmd_i.dev;
               tag_blk_in = cmd_i.blk;
               present_in = 1'b1;
               valid_in   = 1'b1;
               count_in   = COUNT_ONE;
            end
            CMD_PIN: begin
               if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_ONE;
            end
            CMD_DEC: begin
               if (count_ff != '0) count_in = count_ff - COUNT_ONE;
            end
            CMD_RELEASE: begin
               if (count_ff != '0) count_in = count_ff - COUNT_ONE;
               time_in = {1'b0, cmd_i.tick};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         valid_ff   <= 1'b0;
         count_ff   <= '0;
         time_ff    <= TIME_NEVER;
         carry_ff   <= '0;
      end else begin
         present_ff <= present_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         time_ff    <= time_in;
         carry_ff   <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_dev_ff   <= tag_dev_in;
      tag_blk_ff   <= tag_blk_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      free_time_ff <= free_time_in;
   end

   assign carry_o     = carry_ff;
   assign hit_idx_o   = hit_idx_ff;
   assign free_idx_o  = free_idx_ff;
   assign free_time_o = free_time_ff;
   assign zero_o      = (count_ff == '0);

endmodule

`default_nettype wire

/* design/lru_block_buffer_cache_top.sv */
// Block buffer cache manager: a get goes from idle through the scan state to
// the commit state; release, pin and unpin go from idle straight to commit,
// which registers the response. The next request is taken back in idle. A result
// held back by the receiver stalls the input. The get time is set by the lookup
// token, which walks the row of entry cells one cell per cycle. Synchronous
// reset empties every entry, clears counts and sets last-use times to minus one.
`default_nettype none
`include "lru_block_buffer_cache_top_defines.svh"

module lru_block_buffer_cache_top #(
   parameter int NUM_BUFFERS = 32
) (
   input  wire     clock,
   input  wire     reset,
   lbc_req_if.sink   req_ch,
   lbc_rsp_if.source rsp_ch
);
   import lbc_pkg::*;

   localparam int IDX_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int WIDE_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

   // The controller idles, for a get waits for the token to leave the last cell,
   // and then commits the update together with the response beat.
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      start_ff, start_in;

   // Request fields held for the whole operation.
   func_type          func_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [TICK_W-1:0] tick_ff;

   // Token as it left the last cell.
   logic              fin_hit_ff, fin_hit_valid_ff, fin_free_ff;
   logic [IDX_W-1:0]  fin_hit_idx_ff, fin_free_idx_ff;

   // Response register; it decouples the result beat from the next request.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_hit_ff, rsp_read_ff;
   status_type        rsp_status_ff;

   logic              req_fire;
   logic              out_free;
   logic              commit_go;
   logic              scan_done;

   cmd_op_type        cmd_op;
   logic [IDX_W-1:0]  cmd_idx;
   cmd_type           cmd_bus;
   logic [SLOT_W-1:0] out_slot;
   logic              out_hit, out_read;
   status_type        out_status;

   logic [WIDE_W-1:0] slot_wide, hit_wide, free_wide;
   logic              slot_ok;
   logic [IDX_W-1:0]  slot_idx;

   // The chain of cells; position 0 is fed by the controller.
   carry_type         chain_carry [NUM_BUFFERS+1];
   logic [IDX_W-1:0]  chain_hit_idx [NUM_BUFFERS+1];
   logic [IDX_W-1:0]  chain_free_idx [NUM_BUFFERS+1];
   logic [TIME_W-1:0] chain_free_time [NUM_BUFFERS+1];
   logic [NUM_BUFFERS-1:0] zero_vec;

   assign chain_carry[0]     = '{active: start_ff, hit: 1'b0, hit_valid: 1'b0, free: 1'b0};
   assign chain_hit_idx[0]   = '0;
   assign chain_free_idx[0]  = '0;
   assign chain_free_time[0] = TIME_NEVER;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_BUFFERS; gi++) begin : g_cell
         lbc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd_i       (cmd_bus),
            .cmd_idx_i   (cmd_idx),
            .carry_i     (chain_carry[gi]),
            .hit_idx_i   (chain_hit_idx[gi]),
            .free_idx_i  (chain_free_idx[gi]),
            .free_time_i (chain_free_time[gi]),
            .carry_o     (chain_carry[gi+1]),
            .hit_idx_o   (chain_hit_idx[gi+1]),
            .free_idx_o  (chain_free_idx[gi+1]),
            .free_time_o (chain_free_time[gi+1]),
            .zero_o      (zero_vec[gi])
         );
      end
   endgenerate

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign commit_go    = (state_ff == S_COMMIT) && out_free;
   assign scan_done    = chain_carry[NUM_BUFFERS].active;

   always_comb begin
      state_in = state_ff;
      start_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.func == FN_GET) begin
                  state_in = S_SCAN;
                  start_in = 1'b1;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_SCAN: begin
            if (scan_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Work out the entry update and the response for the held request.
   always_comb begin
      cmd_op     = CMD_NONE;
      cmd_idx    = '0;
      out_slot   = '0;
      out_hit    = 1'b0;
      out_read   = 1'b0;
      out_status = ST_OK;

      slot_wide = WIDE_W'(slot_ff);
      slot_ok   = slot_wide < WIDE_W'(NUM_BUFFERS);
      slot_idx  = slot_wide[IDX_W-1:0];
      hit_wide  = WIDE_W'(fin_hit_idx_ff);
      free_wide = WIDE_W'(fin_free_idx_ff);

      if (func_ff == FN_GET) begin
         if (fin_hit_ff) begin
            cmd_op   = CMD_HIT;
            cmd_idx  = fin_hit_idx_ff;
            out_slot = hit_wide[SLOT_W-1:0];
            out_hit  = 1'b1;
            out_read = !fin_hit_valid_ff;
         end else if (fin_free_ff) begin
            cmd_op   = CMD_FILL;
            cmd_idx  = fin_free_idx_ff;
            out_slot = free_wide[SLOT_W-1:0];
            out_read = 1'b1;
         end else begin
            out_status = ST_NO_FREE;
         end
      end else begin
         out_slot = slot_ff;
         cmd_idx  = slot_idx;
         if (slot_ok) begin
            if (func_ff == FN_PIN) begin
               cmd_op = CMD_PIN;
            end else begin
               cmd_op = (func_ff == FN_RELEASE) ? CMD_RELEASE : CMD_DEC;
               if (zero_vec[slot_idx]) out_status = ST_UNDERFLOW;
            end
         end
      end

      cmd_bus.op   = commit_go ? cmd_op : CMD_NONE;
      cmd_bus.dev  = dev_ff;
      cmd_bus.blk  = blk_ff;
      cmd_bus.tick = tick_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= req_ch.func;
         dev_ff  <= req_ch.device_number;
         blk_ff  <= req_ch.block_number;
         slot_ff <= req_ch.buffer_slot;
         tick_ff <= req_ch.now_tick;
      end
      if (scan_done) begin
         fin_hit_ff       <= chain_carry[NUM_BUFFERS].hit;
         fin_hit_valid_ff <= chain_carry[NUM_BUFFERS].hit_valid;
         fin_free_ff      <= chain_carry[NUM_BUFFERS].free;
         fin_hit_idx_ff   <= chain_hit_idx[NUM_BUFFERS];
         fin_free_idx_ff  <= chain_free_idx[NUM_BUFFERS];
      end
      if (commit_go) begin
         rsp_slot_ff   <= out_slot;
         rsp_hit_ff    <= out_hit;
         rsp_read_ff   <= out_read;
         rsp_status_ff <= out_status;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.slot_index = rsp_slot_ff;
   assign rsp_ch.was_hit    = rsp_hit_ff;
   assign rsp_ch.needs_read = rsp_read_ff;
   assign rsp_ch.status     = rsp_status_ff;

   // An accepted request always moves the controller out of idle.
   `LBC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE)
   // The token only reaches the end of the row while a get is scanning.
   `LBC_ASSERT_SAME(a_token_only_in_scan, clock, reset, scan_done, state_ff == S_SCAN)
   // A commit always leaves a result beat waiting in the response register.
   `LBC_ASSERT_NEXT(a_commit_loads_rsp, clock, reset, commit_go, rsp_valid_ff)

endmodule

`default_nettype wire

/* verif/tb_lru_block_buffer_cache_top.sv */
// Self-checking testbench of the block buffer cache manager (lru_block_buffer_cache_top).
// Depends on lbc_pkg, the lbc_req_if / lbc_rsp_if channel interfaces and the top level.
`timescale 1ns / 1ps

module tb_lru_block_buffer_cache_top;
   import lbc_pkg::*;

   localparam int NUM_BUFFERS     = 32;
   localparam int MAX_WAIT        = 11;    // longest random gap on either side
   localparam int PRESSURE_CYCLES = 500;   // the one long hold-off of the receiver
   localparam int WATCHDOG_LIMIT  = 4000;  // cycles without any beat before giving up
   localparam int SEGMENTS        = 7;
   localparam int SEGMENT_ITEMS   = 60;
   localparam int POOL_SIZE       = 64;
   localparam int DIRECTED_ROWS   = 22;

   // One request beat and one response beat, at the widths of the ports.
   typedef struct packed {
      func_type          func;
      logic [DEV_W-1:0]  dev;
      logic [BLK_W-1:0]  blk;
      logic [SLOT_W-1:0] slot;
      logic [TICK_W-1:0] tick;
   } cache_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              was_hit;
      logic              needs_read;
      status_type        status;
   } cache_rsp_type;

   // A row of the directed table. Where typed is set, rsp is the response
   // worked out by hand; otherwise the predictor supplies it.
   typedef struct packed {
      cache_req_type req;
      logic          typed;
      cache_rsp_type rsp;
   } directed_row_type;

   localparam cache_rsp_type ANY_RSP = '0;

   // The directed part: extremes of every field, all four operations, the
   // lowest-index tie break among never-released entries, hits, and reference
   // count underflow on both release and unpin.
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      // Right after reset every entry is free and equally old, so entry 0 wins.
      '{'{FN_GET,     8'h00, 32'h0000_0000, 5'd0,  31'h0000_0000}, 1'b1,
        '{5'd0,  1'b0, 1'b1, ST_OK}},
      '{'{FN_GET,     8'hFF, 32'hFFFF_FFFF, 5'd31, 31'h7FFF_FFFF}, 1'b1,
        '{5'd1,  1'b0, 1'b1, ST_OK}},
      // The same block again is a hit on entry 0; its data is already valid.
      '{'{FN_GET,     8'h00, 32'h0000_0000, 5'd0,  31'h0000_0000}, 1'b1,
        '{5'd0,  1'b1, 1'b0, ST_OK}},
      '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  31'h7FFF_FFFF}, 1'b1,
        '{5'd0,  1'b0, 1'b0, ST_OK}},
      '{'{FN_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0,  31'h0000_0000}, 1'b1,
        '{5'd0,  1'b0, 1'b0, ST_OK}},
      // Count is zero now: underflow, although the time is still stamped.
      '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  31'h0000_0005}, 1'b1,
        '{5'd0,  1'b0, 1'b0, ST_UNDERFLOW}},
      '{'{FN_UNPIN,   8'h00, 32'h0000_0000, 5'd31, 31'h0000_0000}, 1'b1,
        '{5'd31, 1'b0, 1'b0, ST_UNDERFLOW}},
      '{'{FN_PIN,     8'h00, 32'h0000_0000, 5'd31, 31'h0000_0000}, 1'b1,
        '{5'd31, 1'b0, 1'b0, ST_OK}},
      '{'{FN_UNPIN,   8'h00, 32'h0000_0000, 5'd31, 31'h0000_0000}, 1'b1,
        '{5'd31, 1'b0, 1'b0, ST_OK}},
      '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd1,  31'd100}, 1'b0, ANY_RSP},
      '{'{FN_GET,     8'h12, 32'hA5A5_A5A5, 5'd0,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_GET,     8'h00, 32'h0000_0000, 5'd0,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_GET,     8'hFF, 32'hFFFF_FFFF, 5'd0,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_PIN,     8'h00, 32'h0000_0000, 5'd2,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd2,  31'h2AAA_AAAA}, 1'b0, ANY_RSP},
      '{'{FN_GET,     8'h01, 32'h0000_0001, 5'd0,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 31'h5555_5555}, 1'b1,
        '{5'd31, 1'b0, 1'b0, ST_UNDERFLOW}},
      '{'{FN_GET,     8'h00, 32'h0000_0001, 5'd0,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_UNPIN,   8'h00, 32'h0000_0000, 5'd0,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_GET,     8'h01, 32'h0000_0000, 5'd0,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd3,  31'h0000_0000}, 1'b0, ANY_RSP},
      '{'{FN_UNPIN,   8'h00, 32'h0000_0000, 5'd3,  31'h0000_0000}, 1'b0, ANY_RSP}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbc_req_if req_ch ();
   lbc_rsp_if rsp_ch ();

   lru_block_buffer_cache_top #(
      .NUM_BUFFERS(NUM_BUFFERS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #2 clock = ~clock;

   // Shadow copy of the cache bookkeeping, advanced once per accepted request.
   logic [DEV_W-1:0]   shadow_dev   [NUM_BUFFERS];
   logic [BLK_W-1:0]   shadow_blk   [NUM_BUFFERS];
   logic               shadow_tagged[NUM_BUFFERS];
   logic               shadow_valid [NUM_BUFFERS];
   logic [COUNT_W-1:0] shadow_refs  [NUM_BUFFERS];
   logic [TIME_W-1:0]  shadow_used  [NUM_BUFFERS];

   // Responses still owed by the block, oldest first.
   cache_rsp_type owed_rsp [$];

   // Blocks that the random part asks for again and again, so that hits,
   // evictions of tagged entries and re-fetches of evicted blocks all occur.
   logic [DEV_W-1:0] pool_dev [POOL_SIZE];
   logic [BLK_W-1:0] pool_blk [POOL_SIZE];
   logic [TICK_W-1:0] tick_base = '0;

   // Shared between the sender and the receiver, but for hold_done, which only the receiver uses.
   bit no_idle    = 1'b0;   // both sides run without gaps while set
   bit want_hold  = 1'b0;   // asks the receiver for its one long hold-off
   bit hold_done  = 1'b0;

   int fail_count  = 0;
   int sent_count  = 0;
   int hit_count   = 0;
   int miss_count  = 0;
   int full_count  = 0;
   int under_count = 0;
   int sat_count   = 0;
   int idle_cycles = 0;

   // Clear the shadow state the way reset clears the block.
   function automatic void shadow_reset();
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         shadow_dev[i]    = '0;
         shadow_blk[i]    = '0;
         shadow_tagged[i] = 1'b0;
         shadow_valid[i]  = 1'b0;
         shadow_refs[i]   = '0;
         shadow_used[i]   = TIME_NEVER;
      end
   endfunction

   // Work out the response to one request and apply its effect to the shadow.
   function automatic cache_rsp_type cache_lookup(input cache_req_type r);
      cache_rsp_type rsp;
      bit            found;
      int            pick;
      rsp   = '0;
      found = 1'b0;
      pick  = 0;
      if (r.func == FN_GET) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            if (!found && shadow_tagged[i] && shadow_dev[i] == r.dev &&
                shadow_blk[i] == r.blk) begin
               found = 1'b1;
               pick  = i;
            end
         end
         if (found) begin
            if (shadow_refs[pick] != COUNT_MAX)
               shadow_refs[pick]++;
            else
               sat_count++;
            rsp.slot_index = SLOT_W'(pick);
            rsp.was_hit    = 1'b1;
            rsp.needs_read = !shadow_valid[pick];
            shadow_valid[pick] = 1'b1;
         end else begin
            // Victim: the free entry with the oldest signed last-use time,
            // the lowest index winning ties.
            for (int i = 0; i < NUM_BUFFERS; i++) begin
               if (shadow_refs[i] == '0 &&
                   (!found || $signed(shadow_used[i]) < $signed(shadow_used[pick]))) begin
                  found = 1'b1;
                  pick  = i;
               end
            end
            if (!found) begin
               rsp.status = ST_NO_FREE;
            end else begin
               shadow_dev[pick]    = r.dev;
               shadow_blk[pick]    = r.blk;
               shadow_tagged[pick] = 1'b1;
               shadow_valid[pick]  = 1'b1;
               shadow_refs[pick]   = COUNT_ONE;
               rsp.slot_index = SLOT_W'(pick);
               rsp.needs_read = 1'b1;
            end
         end
      end else begin
         rsp.slot_index = r.slot;
         if (int'(r.slot) < NUM_BUFFERS) begin
            if (r.func == FN_PIN) begin
               if (shadow_refs[r.slot] != COUNT_MAX)
                  shadow_refs[r.slot]++;
               else
                  sat_count++;
            end else begin
               if (shadow_refs[r.slot] == '0)
                  rsp.status = ST_UNDERFLOW;
               else
                  shadow_refs[r.slot]--;
               if (r.func == FN_RELEASE)
                  shadow_used[r.slot] = {1'b0, r.tick};
            end
         end
      end
      return rsp;
   endfunction

   // An entry that currently holds a reference, searched from a random start,
   // or -1 when every count is zero.
   function automatic int held_slot();
      int start;
      int idx;
      start = $urandom_range(0, NUM_BUFFERS - 1);
      for (int k = 0; k < NUM_BUFFERS; k++) begin
         idx = (start + k) % NUM_BUFFERS;
         if (shadow_refs[idx] != '0)
            return idx;
      end
      return -1;
   endfunction

   // Time mostly moves forward; now and then a wild value shakes up the ages.
   function automatic logic [TICK_W-1:0] next_tick();
      tick_base = tick_base + TICK_W'($urandom_range(1, 5000));
      if ($urandom_range(0, 15) == 0)
         return TICK_W'($urandom);
      return tick_base;
   endfunction

   // One random request. Mode 0 leans toward gets and fills the cache until
   // it runs out of free entries, mode 1 leans toward releases and drains it,
   // mode 2 sits between. Most releases, pins and unpins address an entry that
   // is really held; a tenth of the requests hit arbitrary entries instead.
   function automatic cache_req_type random_request(input int mode);
      cache_req_type r;
      int            roll;
      int            get_pct;
      int            held;
      int            idx;
      int            sub;
      roll    = $urandom_range(0, 99);
      get_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
      held    = held_slot();
      r.func  = FN_GET;
      r.dev   = DEV_W'($urandom);
      r.blk   = $urandom;
      r.slot  = SLOT_W'($urandom);
      r.tick  = next_tick();
      if (roll < get_pct || held < 0) begin
         if ($urandom_range(0, 1) == 1) begin
            idx   = $urandom_range(0, POOL_SIZE - 1);
            r.dev = pool_dev[idx];
            r.blk = pool_blk[idx];
         end
      end else if (roll < 90) begin
         sub    = $urandom_range(0, 9);
         r.slot = SLOT_W'(held);
         r.func = (sub < 7) ? FN_RELEASE : (sub == 7) ? FN_PIN : FN_UNPIN;
      end else begin
         r.func = func_type'($urandom_range(1, 3));
      end
      return r;
   endfunction

   // Offer one request after a random gap (none while no_idle is set) and hold
   // it until the block takes it. The expected response is queued at the beat
   // itself, so the queue is in the order in which the block sees the requests.
   task automatic send_request(input cache_req_type r, input logic typed,
                               input cache_rsp_type typed_rsp);
      int            gap;
      cache_rsp_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.func          <= r.func;
      req_ch.device_number <= r.dev;
      req_ch.block_number  <= r.blk;
      req_ch.buffer_slot   <= r.slot;
      req_ch.now_tick      <= r.tick;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      predicted = cache_lookup(r);
      owed_rsp.push_back(typed ? typed_rsp : predicted);
      sent_count++;
      if (predicted.status == ST_NO_FREE)
         full_count++;
      else if (predicted.status == ST_UNDERFLOW)
         under_count++;
      else if (r.func == FN_GET && predicted.was_hit)
         hit_count++;
      else if (r.func == FN_GET)
         miss_count++;
   endtask

   // Every input starts at a known value before the first clock edge.
   initial begin
      req_ch.valid         = 1'b0;
      req_ch.func          = FN_GET;
      req_ch.device_number = '0;
      req_ch.block_number  = '0;
      req_ch.buffer_slot   = '0;
      req_ch.now_tick      = '0;
      rsp_ch.ready         = 1'b0;
   end

   // Response side: a random stall before each beat, none while the sender runs
   // gap-free, and once a long hold-off during which the block fills up and stops
   // taking requests. Every response beat is compared field by field with the
   // oldest owed response.
   initial begin : response_side
      int            stall;
      cache_rsp_type want;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (want_hold && !hold_done) begin
            stall     = PRESSURE_CYCLES;
            hold_done = 1'b1;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         if (owed_rsp.size() == 0) begin
            $error("response beat with no request outstanding: slot_index %0d status %0d",
                   rsp_ch.slot_index, rsp_ch.status);
            fail_count++;
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_ch.slot_index !== want.slot_index) begin
               $error("slot_index mismatch: expected %0d, got %0d",
                      want.slot_index, rsp_ch.slot_index);
               fail_count++;
            end
            if (rsp_ch.was_hit !== want.was_hit) begin
               $error("was_hit mismatch: expected %0d, got %0d",
                      want.was_hit, rsp_ch.was_hit);
               fail_count++;
            end
            if (rsp_ch.needs_read !== want.needs_read) begin
               $error("needs_read mismatch: expected %0d, got %0d",
                      want.needs_read, rsp_ch.needs_read);
               fail_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d",
                      want.status, rsp_ch.status);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a run in which no beat moves on either channel for too long
   // has hung. The limit covers the long hold-off plus a full get lookup.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles with %0d responses owed.",
                  idle_cycles, owed_rsp.size());
         $display("tb_lru_block_buffer_cache_top NOT OK");
         $finish;
      end
   end

   // Request side and end of test.
   initial begin : request_side
      cache_req_type fixed_req;
      shadow_reset();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_dev[i] = DEV_W'($urandom_range(0, 3));
         pool_blk[i] = $urandom;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_ROWS; n++)
         send_request(directed_table[n].req, directed_table[n].typed, directed_table[n].rsp);

      // Pin one entry well past the top of its count so it saturates, then
      // unpin it a few steps back below the ceiling.
      no_idle   = 1'b1;
      fixed_req = '{FN_PIN, 8'h00, 32'h0000_0000, 5'd31, 31'h0000_0000};
      for (int n = 0; n < 258; n++)
         send_request(fixed_req, 1'b0, ANY_RSP);
      fixed_req.func = FN_UNPIN;
      for (int n = 0; n < 4; n++)
         send_request(fixed_req, 1'b0, ANY_RSP);

      // Random part: fill, drain and mixed segments in turn, some of them
      // without any idling. The long receiver hold-off lands in the first one.
      want_hold = 1'b1;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < SEGMENT_ITEMS; n++)
            send_request(random_request(seg % 3), 1'b0, ANY_RSP);
      end
      no_idle = 1'b0;
      req_ch.valid <= 1'b0;

      // Drain: wait for every owed response, then a full lookup time more so
      // that a stray extra response would still show up.
      while (owed_rsp.size() != 0)
         @(posedge clock);
      repeat (NUM_BUFFERS + 8) @(posedge clock);

      $display("Ran %0d requests: %0d get hits, %0d get misses, %0d with no free buffer.",
               sent_count, hit_count, miss_count, full_count);
      $display("Saw %0d count underflows, %0d saturated count steps, one %0d-cycle stall.",
               under_count, sat_count, PRESSURE_CYCLES);
      if (fail_count == 0) begin
         $display("tb_lru_block_buffer_cache_top OK");
      end else begin
         $display("tb_lru_block_buffer_cache_top NOT OK");
      end
      $finish;
   end

endmodule
